>>> rtl/aes_pkg.sv
// ----------------------------------------------------------------------------
// aes_pkg
// shared constants, types and byte-level functions for the aes-256 engine
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int BLOCK_COLUMNS = 4;
    localparam int KEY_WORDS     = 8;
    localparam int ROUNDS        = 14;
    localparam int STORE_WORDS   = BLOCK_COLUMNS * (ROUNDS + 1);
    localparam int RK_AW         = $clog2(STORE_WORDS);
    localparam int RK_ROWS       = ROUNDS + 1;
    localparam int RK_RW         = $clog2(RK_ROWS);
    localparam int CFG_AW        = 2;

    localparam logic [CFG_AW-1:0] REG_KEY_PART0 = 2'd0;
    localparam logic [CFG_AW-1:0] REG_KEY_PART1 = 2'd1;
    localparam logic [CFG_AW-1:0] REG_KEY_PART2 = 2'd2;
    localparam logic [CFG_AW-1:0] REG_KEY_PART3 = 2'd3;

    localparam logic [7:0] POLY_LOW = 8'h1b;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_KEY_LOAD,
        ST_ROUND,
        ST_DONE
    } t_state;

    // round-key row read request from the cipher core
    typedef struct packed {
        logic             rd_en;
        logic [RK_RW-1:0] rd_addr;
    } t_rk_req;

    typedef struct packed {
        logic start;
    } t_kx_ctrl;

    function automatic logic [7:0] xtime(input logic [7:0] v);
        xtime = {v[6:0], 1'b0} ^ (v[7] ? POLY_LOW : 8'h00);
    endfunction

    function automatic logic [7:0] fwd_box(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        fwd_box = t[a];
    endfunction

    function automatic logic [7:0] inv_box(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        inv_box = t[a];
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {fwd_box(w[31:24]), fwd_box(w[23:16]), fwd_box(w[15:8]), fwd_box(w[7:0])};
    endfunction

    // forward column mix: 2 3 1 1
    function automatic logic [31:0] mix_fwd(input logic [31:0] c);
        logic [7:0] a0, a1, a2, a3;
        a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
        mix_fwd = {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                   a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                   a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                   xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
    endfunction

    // inverse column mix: 14 11 13 9
    function automatic logic [31:0] mix_inv(input logic [31:0] c);
        logic [7:0] a [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        logic [7:0] m9 [4];
        logic [7:0] mb [4];
        logic [7:0] md [4];
        logic [7:0] me [4];
        a[0] = c[31:24]; a[1] = c[23:16]; a[2] = c[15:8]; a[3] = c[7:0];
        for (int k = 0; k < 4; k++) begin
            x2[k] = xtime(a[k]);
            x4[k] = xtime(x2[k]);
            x8[k] = xtime(x4[k]);
            m9[k] = x8[k] ^ a[k];
            mb[k] = x8[k] ^ x2[k] ^ a[k];
            md[k] = x8[k] ^ x4[k] ^ a[k];
            me[k] = x8[k] ^ x4[k] ^ x2[k];
        end
        mix_inv = {me[0] ^ mb[1] ^ md[2] ^ m9[3],
                   m9[0] ^ me[1] ^ mb[2] ^ md[3],
                   md[0] ^ m9[1] ^ me[2] ^ mb[3],
                   mb[0] ^ md[1] ^ m9[2] ^ me[3]};
    endfunction

endpackage

>>> rtl/aes256_block_cipher.sv
// ----------------------------------------------------------------------------
// aes256_block_cipher
// aes-256 encrypt/decrypt engine with on-chip key schedule
//
//  channel | handshake          | payload
//  in      | i_valid / o_ready  | i_kind, i_block_high, i_block_low
//  out     | o_valid / i_ready  | o_result_high, o_result_low
//  cfg     | i_cfg_we           | i_cfg_index, i_cfg_data
//
// a block runs from input beat to result beat through the key fetch, the
// round state (initial add plus 14 rounds), then the result beat; the idle
// state follows before the next input beat
// the first block after reset or a key write adds the key schedule first,
// one word per cycle from the schedule sequencer
// reset is synchronous; the result register holds until taken, and the next
// beat is accepted only after it leaves
// ----------------------------------------------------------------------------
module aes256_block_cipher
    import aes_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_index,
    input  logic [63:0]       i_cfg_data,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_kind,
    input  logic [63:0]       i_block_high,
    input  logic [63:0]       i_block_low,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [63:0]       o_result_high,
    output logic [63:0]       o_result_low
);

    t_state           r_state, n_state;
    logic [255:0]     r_key;
    logic             r_keys_ready;
    logic             r_inv;
    logic [127:0]     r_blk;
    logic [3:0]       r_rnd, n_rnd;
    logic             r_first;
    t_kx_ctrl         w_kx;
    t_rk_req          w_req;
    logic [127:0]     w_rk;
    logic             w_kx_done;
    logic [127:0]     w_round;
    logic             w_acc;
    logic             w_last;
    logic [3:0]       w_fetch;

    assign w_acc = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key        <= '0;
            r_keys_ready <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_KEY_PART0: r_key[255:192] <= i_cfg_data;
                    REG_KEY_PART1: r_key[191:128] <= i_cfg_data;
                    REG_KEY_PART2: r_key[127:64]  <= i_cfg_data;
                    REG_KEY_PART3: r_key[63:0]    <= i_cfg_data;
                    default: ;
                endcase
                r_keys_ready <= 1'b0;
            end else if (w_kx_done) begin
                r_keys_ready <= 1'b1;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:     if (w_acc) n_state = r_keys_ready ? ST_KEY_LOAD : ST_EXPAND;
            ST_EXPAND:   if (w_kx_done) n_state = ST_KEY_LOAD;
            ST_KEY_LOAD: n_state = ST_ROUND;
            ST_ROUND:    if (r_rnd == 4'(ROUNDS)) n_state = ST_DONE;
            ST_DONE:     if (i_ready) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_last = r_rnd == 4'(ROUNDS);
        o_ready = r_state == ST_IDLE;
        o_valid = r_state == ST_DONE;
        w_kx.start = w_acc && !r_keys_ready;
        n_rnd = (r_state == ST_KEY_LOAD) ? 4'd0 : r_rnd + 4'd1;
        w_fetch = (r_state == ST_KEY_LOAD) ? 4'd0 : r_rnd + 4'd1;
        w_req.rd_en   = r_state == ST_KEY_LOAD || (r_state == ST_ROUND && !w_last);
        w_req.rd_addr = r_inv ? RK_RW'(ROUNDS - int'(w_fetch))
                              : RK_RW'(w_fetch);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_inv <= i_kind;
            r_blk <= {i_block_high, i_block_low};
        end else if (r_state == ST_ROUND) begin
            r_blk <= r_first ? (r_blk ^ w_rk) : w_round;
        end
        if (r_state == ST_KEY_LOAD || r_state == ST_ROUND) begin
            r_rnd <= n_rnd;
        end
        r_first <= r_state == ST_KEY_LOAD;
    end

    aes_key_expand u_kx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_kx),
        .i_key   (r_key),
        .i_req   (w_req),
        .o_rk    (w_rk),
        .o_done  (w_kx_done)
    );

    aes_round u_round (
        .i_state (r_blk),
        .i_rk    (w_rk),
        .i_inv   (r_inv),
        .i_last  (w_last),
        .o_state (w_round)
    );

    assign o_result_high = r_blk[127:64];
    assign o_result_low  = r_blk[63:0];

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_ready) else $error("ready while busy");
    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_result_high)))
        else $error("result dropped");
    a_expand_before_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXPAND && w_kx_done) |=> r_state == ST_KEY_LOAD) else $error("expand exit");

endmodule

>>> rtl/aes_key_expand.sv
// ----------------------------------------------------------------------------
// aes_key_expand
// key schedule sequencer: one round-key word per cycle into the key memory,
// read port serves the cipher core one 128-bit round key per cycle
// ----------------------------------------------------------------------------
module aes_key_expand
    import aes_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_kx_ctrl          i_ctrl,
    input  logic [255:0]      i_key,
    input  t_rk_req           i_req,
    output logic [127:0]      o_rk,
    output logic              o_done
);

    logic [127:0]     r_mem [RK_ROWS];
    logic [31:0]      r_win [KEY_WORDS];
    logic [RK_AW-1:0] r_idx;
    logic [7:0]       r_rc;
    logic             r_busy;
    logic [127:0]     r_rk;
    logic [31:0]      w_t;
    logic [31:0]      w_new;

    always_comb begin
        w_t = r_win[KEY_WORDS-1];
        if (r_idx[2:0] == 3'd0)
            w_t = sub_word({w_t[23:0], w_t[31:24]}) ^ {r_rc, 24'h0};
        else if (r_idx[2:0] == 3'd4)
            w_t = sub_word(w_t);
        w_new = r_win[0] ^ w_t;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_ctrl.start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_idx == RK_AW'(STORE_WORDS - 1)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            for (int k = 0; k < KEY_WORDS; k++) begin
                r_win[k] <= i_key[255-32*k -: 32];
            end
            r_idx <= RK_AW'(KEY_WORDS);
            r_rc  <= 8'h01;
        end else if (r_busy) begin
            for (int k = 0; k < KEY_WORDS - 1; k++) begin
                r_win[k] <= r_win[k+1];
            end
            r_win[KEY_WORDS-1] <= w_new;
            r_idx <= r_idx + 1'b1;
            if (r_idx[2:0] == 3'd0)
                r_rc <= xtime(r_rc);
        end
    end

    // first two rows written from the key directly, the rest word by word
    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_mem[0] <= i_key[255:128];
            r_mem[1] <= i_key[127:0];
        end else if (r_busy) begin
            r_mem[r_idx[RK_AW-1:2]][127-32*r_idx[1:0] -: 32] <= w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rk <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rk   = r_rk;
    assign o_done = r_busy && r_idx == RK_AW'(STORE_WORDS - 1);

endmodule

>>> rtl/aes_round.sv
// ----------------------------------------------------------------------------
// aes_round
// shared round unit: one forward or inverse round on the 128-bit state
// ----------------------------------------------------------------------------
module aes_round
    import aes_pkg::*;
(
    input  logic [127:0] i_state,
    input  logic [127:0] i_rk,
    input  logic         i_inv,
    input  logic         i_last,
    output logic [127:0] o_state
);

    logic [7:0]   w_b [16];
    logic [7:0]   w_s [16];
    logic [31:0]  w_col [4];
    logic [31:0]  w_kc [4];
    logic [127:0] w_sr;

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            w_b[i] = i_state[127-8*i -: 8];
        end
        // shift rows then byte substitution (they commute)
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                if (i_inv)
                    w_s[r + 4*((c + r) % 4)] = inv_box(w_b[r + 4*c]);
                else
                    w_s[r + 4*c] = fwd_box(w_b[r + 4*((c + r) % 4)]);
            end
        end
        for (int i = 0; i < 16; i++) begin
            w_sr[127-8*i -: 8] = w_s[i];
        end
        for (int c = 0; c < 4; c++) begin
            w_kc[c] = w_sr[127-32*c -: 32];
            if (i_inv) begin
                w_kc[c] = w_kc[c] ^ i_rk[127-32*c -: 32];
                w_col[c] = i_last ? w_kc[c] : mix_inv(w_kc[c]);
            end else begin
                w_col[c] = (i_last ? w_kc[c] : mix_fwd(w_kc[c])) ^ i_rk[127-32*c -: 32];
            end
            o_state[127-32*c -: 32] = w_col[c];
        end
    end

endmodule
